@@ hw/rtl/mns_pkg.sv @@
// Shared types and constants for the melody note sequencer voice.
// Used by melody_note_sequencer_core; depends on nothing else.
package mns_pkg;

    // Field widths
    localparam int unsigned ENTRY_W   = 9;
    localparam int unsigned HALF_W    = 15;
    localparam int unsigned BEATS_W   = 4;
    localparam int unsigned INDEX_W   = 9;
    localparam int unsigned MSTART_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 9;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTRO_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_START   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_LENGTH  = 2'd2;

    // Configuration reset values
    localparam logic [INDEX_W-1:0]  RST_INTRO_LENGTH = 9'd31;
    localparam logic [MSTART_W-1:0] RST_MAIN_START   = 8'd31;
    localparam logic [INDEX_W-1:0]  RST_MAIN_LENGTH  = 9'd212;

    // Full tone periods, one per pitch index
    localparam logic [0:63][15:0] PITCH_TABLE = {
        16'd1204,  16'd1276,  16'd1352,  16'd1432,  16'd1516,  16'd1608,  16'd1704,
        16'd1804,  16'd1912,  16'd2024,  16'd2144,  16'd2272,  16'd2408,  16'd2552,
        16'd2704,  16'd2864,  16'd3032,  16'd3216,  16'd3404,  16'd3608,  16'd3824,
        16'd4048,  16'd4292,  16'd4544,  16'd4816,  16'd5104,  16'd5404,  16'd5728,
        16'd6068,  16'd6428,  16'd6812,  16'd7216,  16'd7644,  16'd8100,  16'd8580,
        16'd9092,  16'd9632,  16'd10204, 16'd10812, 16'd11456, 16'd12136, 16'd12856,
        16'd13620, 16'd14432, 16'd15288, 16'd16200, 16'd17160, 16'd18180, 16'd19264,
        16'd20408, 16'd21620, 16'd22908, 16'd24268, 16'd25712, 16'd27240, 16'd28860,
        16'd30576, 16'd32392, 16'd34324, 16'd36364, 16'd38528, 16'd40816, 16'd43244,
        16'd45820
    };

    // One result beat
    typedef struct packed {
        logic [HALF_W-1:0]  half_period;
        logic               note_started;
        logic [BEATS_W-1:0] beats_remaining;
        logic               in_main;
    } t_result;

    // Half period of a store entry; a zero pitch index is a rest
    function automatic logic [HALF_W-1:0] f_half_period(input logic [ENTRY_W-1:0] entry);
        logic [15:0] period;
        period = PITCH_TABLE[entry[5:0]];
        if (entry[5:0] == 6'd0) begin
            return '0;
        end
        return period[15:1];
    endfunction

    // Beat count of a store entry: 2^code - 1, or a whole note
    function automatic logic [BEATS_W-1:0] f_note_beats(input logic [ENTRY_W-1:0] entry);
        if (entry[8]) begin
            return 4'hF;
        end
        return (4'd1 << entry[7:6]) - 4'd1;
    endfunction

endpackage

@@ hw/rtl/melody_note_sequencer_core.sv @@
// Top level of one melody sequencer voice: note store, play state, output buffer.
// Depends on mns_pkg and mns_ram.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | sink      | i_in_valid / o_in_ready   | req_type, store_address, note_byte,
//          |           |                           | whole_flag
//  out     | source    | o_out_valid / i_out_ready | half_period, note_started,
//          |           |                           | beats_remaining, in_main
//  cfg     | sink      | i_cfg_wr_en (no wait)     | i_cfg_index, i_cfg_wdata
//
// One item per cycle unless stalled; its registered result shows the cycle after on a free head.
// The note store keeps two reads in flight every cycle (next fetch and start address),
// addressed from next-cycle state, so a fetch never waits on the store's read latency.
// Synchronous reset clears play state and reloads config defaults; store contents stay undefined.
// A two-entry output buffer takes items while a result waits; input stalls only when full.
module melody_note_sequencer_core #(
    parameter int unsigned STORE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_wdata,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_store_address,
    input  logic [7:0]  i_note_byte,
    input  logic        i_whole_flag,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_half_period,
    output logic        o_note_started,
    output logic [3:0]  o_beats_remaining,
    output logic        o_in_main
);

    localparam int unsigned AW    = $clog2(STORE_DEPTH);
    localparam int unsigned SUM_W = 10;
    localparam int unsigned LO_W  = 6;
    localparam int unsigned HI_W  = SUM_W - LO_W;

    // Residue tables for the store address split into low and high digits
    function automatic logic [(2**LO_W)-1:0][AW-1:0] f_lo_mod();
        logic [(2**LO_W)-1:0][AW-1:0] t;
        for (int k = 0; k < 2**LO_W; k++) begin
            t[k] = AW'(k % STORE_DEPTH);
        end
        return t;
    endfunction

    function automatic logic [(2**HI_W)-1:0][AW-1:0] f_hi_mod();
        logic [(2**HI_W)-1:0][AW-1:0] t;
        for (int k = 0; k < 2**HI_W; k++) begin
            t[k] = AW'((k * (2**LO_W)) % STORE_DEPTH);
        end
        return t;
    endfunction

    localparam logic [(2**LO_W)-1:0][AW-1:0] LO_MOD = f_lo_mod();
    localparam logic [(2**HI_W)-1:0][AW-1:0] HI_MOD = f_hi_mod();

    // Wrap an address sum onto the store depth
    function automatic logic [AW-1:0] f_store_mod(input logic [SUM_W-1:0] x);
        logic [AW:0] s;
        s = {1'b0, LO_MOD[x[LO_W-1:0]]} + {1'b0, HI_MOD[x[SUM_W-1:LO_W]]};
        if (s >= (AW+1)'(STORE_DEPTH)) begin
            s = s - (AW+1)'(STORE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Configuration
    logic [8:0] r_intro_len, n_intro_len;
    logic [7:0] r_main_start, n_main_start;
    logic [8:0] r_main_len, n_main_len;

    // Play state
    logic [8:0]  r_play_idx, n_play_idx;
    logic [3:0]  r_beats, n_beats;
    logic        r_main, n_main;
    logic        r_run, n_run;
    logic [14:0] r_half, n_half;

    // Output buffer
    mns_pkg::t_result r_hd, n_hd, r_sk, n_sk;
    logic             r_hd_v, n_hd_v, r_sk_v, n_sk_v;

    // Store access
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [8:0]    wentry, q_a, q_b, ent_a, ent_b;
    logic          store_we;
    logic          r_fwd_a, r_fwd_b;
    logic [8:0]    r_fwd_data;

    logic             in_acc;
    logic             started;
    logic             wrap_tick;
    logic             wrap_start;
    logic [8:0]       sec_len;
    mns_pkg::t_result res;

    // Next-fetch address terms
    logic [8:0]       nx_len;
    logic             nx_wrap;
    logic             nx_main;
    logic [8:0]       nx_idx;
    logic [SUM_W-1:0] nx_sum;

    assign in_acc = i_in_valid & o_in_ready;

    // Take configuration writes; reset reloads defaults
    always_comb begin
        n_intro_len  = r_intro_len;
        n_main_start = r_main_start;
        n_main_len   = r_main_len;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mns_pkg::CFG_INTRO_LENGTH: n_intro_len  = i_cfg_wdata;
                mns_pkg::CFG_MAIN_START:   n_main_start = i_cfg_wdata[7:0];
                mns_pkg::CFG_MAIN_LENGTH:  n_main_len   = i_cfg_wdata;
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            n_intro_len  = mns_pkg::RST_INTRO_LENGTH;
            n_main_start = mns_pkg::RST_MAIN_START;
            n_main_len   = mns_pkg::RST_MAIN_LENGTH;
        end
    end

    // Use forwarded write data when the store read collided with a write
    assign ent_a = r_fwd_a ? r_fwd_data : q_a;
    assign ent_b = r_fwd_b ? r_fwd_data : q_b;

    assign sec_len    = r_main ? r_main_len : r_intro_len;
    assign wrap_tick  = (r_play_idx >= sec_len);
    assign wrap_start = (r_intro_len == 9'd0);

    // Advance play state for the accepted beat
    always_comb begin
        n_play_idx = r_play_idx;
        n_beats    = r_beats;
        n_main     = r_main;
        n_run      = r_run;
        n_half     = r_half;
        started    = 1'b0;
        if (in_acc) begin
            case (i_req_type)
                mns_pkg::REQ_START: begin
                    n_run      = 1'b1;
                    n_main     = wrap_start;
                    n_play_idx = 9'd1;
                    n_beats    = mns_pkg::f_note_beats(ent_b);
                    n_half     = mns_pkg::f_half_period(ent_b);
                    started    = 1'b1;
                end
                mns_pkg::REQ_TICK: begin
                    if (r_run) begin
                        if (r_beats == 4'd0) begin
                            n_main     = r_main | wrap_tick;
                            n_play_idx = (wrap_tick ? 9'd0 : r_play_idx) + 9'd1;
                            n_beats    = mns_pkg::f_note_beats(ent_a);
                            n_half     = mns_pkg::f_half_period(ent_a);
                            started    = 1'b1;
                        end else begin
                            n_beats = r_beats - 4'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            n_play_idx = '0;
            n_beats    = '0;
            n_main     = 1'b0;
            n_run      = 1'b0;
            n_half     = '0;
        end
    end

    assign res.half_period     = n_half;
    assign res.note_started    = started;
    assign res.beats_remaining = n_beats;
    assign res.in_main         = n_main;

    // Prefetch address of the next tick fetch, from next-cycle state
    assign nx_len  = n_main ? n_main_len : n_intro_len;
    assign nx_wrap = (n_play_idx >= nx_len);
    assign nx_main = n_main | nx_wrap;
    assign nx_idx  = nx_wrap ? 9'd0 : n_play_idx;
    assign nx_sum  = nx_main ? ({2'b00, n_main_start} + {1'b0, nx_idx}) : {1'b0, nx_idx};
    assign raddr_a = f_store_mod(nx_sum);

    // Prefetch address of a start fetch: intro head, or main head for an empty intro
    assign raddr_b = (n_intro_len == 9'd0) ? f_store_mod({2'b00, n_main_start}) : '0;

    // Store writes
    assign store_we = in_acc & (i_req_type == mns_pkg::REQ_WRITE) & i_rst_n;
    assign waddr    = f_store_mod({2'b00, i_store_address});
    assign wentry   = {i_whole_flag, i_note_byte};

    mns_ram #(
        .WIDTH (mns_pkg::ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_note_store (
        .i_clk     (i_clk),
        .i_we      (store_we),
        .i_waddr   (waddr),
        .i_wdata   (wentry),
        .i_raddr_a (raddr_a),
        .o_rdata_a (q_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (q_b)
    );

    // Hold write data for a read that hits the same address
    always_ff @(posedge i_clk) begin
        r_fwd_a    <= store_we & (waddr == raddr_a);
        r_fwd_b    <= store_we & (waddr == raddr_b);
        r_fwd_data <= wentry;
    end

    // Two-entry output buffer: head drives the port, skid catches a beat under stall
    always_comb begin
        n_hd   = r_hd;
        n_sk   = r_sk;
        n_hd_v = r_hd_v;
        n_sk_v = r_sk_v;
        if (!r_hd_v || i_out_ready) begin
            if (r_sk_v) begin
                n_hd   = r_sk;
                n_hd_v = 1'b1;
                n_sk   = res;
                n_sk_v = in_acc;
            end else begin
                n_hd   = res;
                n_hd_v = in_acc;
            end
        end else if (in_acc) begin
            n_sk   = res;
            n_sk_v = 1'b1;
        end
        if (!i_rst_n) begin
            n_hd_v = 1'b0;
            n_sk_v = 1'b0;
        end
    end

    // Update state registers; reset is folded into the next values
    always_ff @(posedge i_clk) begin
        r_intro_len  <= n_intro_len;
        r_main_start <= n_main_start;
        r_main_len   <= n_main_len;
        r_play_idx   <= n_play_idx;
        r_beats      <= n_beats;
        r_main       <= n_main;
        r_run        <= n_run;
        r_half       <= n_half;
        r_hd         <= n_hd;
        r_sk         <= n_sk;
        r_hd_v       <= n_hd_v;
        r_sk_v       <= n_sk_v;
    end

    assign o_in_ready        = ~r_sk_v;
    assign o_out_valid       = r_hd_v;
    assign o_half_period     = r_hd.half_period;
    assign o_note_started    = r_hd.note_started;
    assign o_beats_remaining = r_hd.beats_remaining;
    assign o_in_main         = r_hd.in_main;

    // Skid holds a beat only behind a held head
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_hd_v)
        else $error("skid beat without head beat");

    // A start beat restarts playback just past the first note
    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == mns_pkg::REQ_START) |=> (r_run && r_play_idx == 9'd1))
        else $error("start beat did not restart playback");

    // A running tick with beats left counts down by one
    a_tick_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == mns_pkg::REQ_TICK && r_run && r_beats != 4'd0)
        |=> (r_beats == $past(r_beats) - 4'd1))
        else $error("tick did not count down");

    // Main section is left only by a start beat
    a_main_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main |=> (r_main || $past(in_acc && i_req_type == mns_pkg::REQ_START)))
        else $error("main section left without start");

endmodule

@@ hw/rtl/mns_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
// Stand-alone; no package dependency.
module mns_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write, and read old contents on both ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ tb/testbench.sv @@
// Testbench for melody_note_sequencer_core: note store writes, playback starts and ticks.
// Checks every result beat against an in-bench model of the voice; needs mns_pkg and the core.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         STORE_SIZE    = 256;
    localparam int         WATCHDOG_IDLE = 5000;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_cfg_wr_en       = 1'b0;
    logic [1:0]  i_cfg_index       = mns_pkg::CFG_INTRO_LENGTH;
    logic [8:0]  i_cfg_wdata       = '0;
    logic        i_in_valid        = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type        = mns_pkg::REQ_TICK;
    logic [7:0]  i_store_address   = '0;
    logic [7:0]  i_note_byte       = '0;
    logic        i_whole_flag      = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready       = 1'b0;
    logic [14:0] o_half_period;
    logic        o_note_started;
    logic [3:0]  o_beats_remaining;
    logic        o_in_main;

    melody_note_sequencer_core #(.STORE_DEPTH(STORE_SIZE)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_store_address   (i_store_address),
        .i_note_byte       (i_note_byte),
        .i_whole_flag      (i_whole_flag),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_half_period     (o_half_period),
        .o_note_started    (o_note_started),
        .o_beats_remaining (o_beats_remaining),
        .o_in_main         (o_in_main)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Voice model state and register copies
    logic [mns_pkg::ENTRY_W-1:0]  note_mem [STORE_SIZE];
    logic [mns_pkg::INDEX_W-1:0]  play_idx     = '0;
    logic [mns_pkg::BEATS_W-1:0]  beats_left   = '0;
    logic                         main_active  = 1'b0;
    logic                         running      = 1'b0;
    logic [mns_pkg::HALF_W-1:0]   cur_half     = '0;
    logic [mns_pkg::INDEX_W-1:0]  intro_len    = mns_pkg::RST_INTRO_LENGTH;
    logic [mns_pkg::MSTART_W-1:0] main_start   = mns_pkg::RST_MAIN_START;
    logic [mns_pkg::INDEX_W-1:0]  main_len     = mns_pkg::RST_MAIN_LENGTH;

    mns_pkg::t_result expected_notes [$];
    int      mismatches   = 0;
    int      burst_left   = 0;
    int      idle_cycles  = 0;
    int      stall_mode   = 0;
    int      stall_run    = 0;

    // Advance to the next note, switching to the main section when the current one runs out
    function automatic void fetch_next_note();
        logic [mns_pkg::INDEX_W-1:0]  section_len;
        logic [7:0]                   addr;
        logic [mns_pkg::ENTRY_W-1:0]  entry;
        logic [15:0]                  period;
        section_len = main_active ? main_len : intro_len;
        if (play_idx >= section_len) begin
            main_active = 1'b1;
            play_idx    = '0;
        end
        if (main_active) begin
            addr = main_start + play_idx[7:0];
        end else begin
            addr = play_idx[7:0];
        end
        entry = note_mem[addr];
        if (entry[8]) begin
            beats_left = 4'd15;
        end else begin
            case (entry[7:6])
                2'd0:    beats_left = 4'd0;
                2'd1:    beats_left = 4'd1;
                2'd2:    beats_left = 4'd3;
                default: beats_left = 4'd7;
            endcase
        end
        period   = mns_pkg::PITCH_TABLE[entry[5:0]];
        cur_half = (entry[5:0] == 6'd0) ? '0 : period[15:1];
        play_idx = play_idx + 1'b1;
    endfunction

    // Apply one input beat to the model and return the result it should produce
    function automatic mns_pkg::t_result predict_voice_step(input logic [1:0] req,
                                                            input logic [7:0] addr,
                                                            input logic [7:0] nbyte,
                                                            input logic       flag);
        mns_pkg::t_result r;
        logic             started;
        started = 1'b0;
        case (req)
            mns_pkg::REQ_WRITE: note_mem[addr] = {flag, nbyte};
            mns_pkg::REQ_START: begin
                running     = 1'b1;
                main_active = 1'b0;
                play_idx    = '0;
                beats_left  = '0;
                fetch_next_note();
                started     = 1'b1;
            end
            mns_pkg::REQ_TICK: begin
                if (running) begin
                    if (beats_left == 4'd0) begin
                        fetch_next_note();
                        started = 1'b1;
                    end else begin
                        beats_left = beats_left - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.half_period     = cur_half;
        r.note_started    = started;
        r.beats_remaining = beats_left;
        r.in_main         = main_active;
        return r;
    endfunction

    // Drive one beat, hold it until accepted, then maybe open a gap
    task automatic send_beat(input logic [1:0] req, input logic [7:0] addr,
                             input logic [7:0] nbyte, input logic flag);
        int gap;
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_store_address <= addr;
        i_note_byte     <= nbyte;
        i_whole_flag    <= flag;
        do @(posedge i_clk); while (!o_in_ready);
        expected_notes.push_back(predict_voice_step(req, addr, nbyte, flag));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
            gap        = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_tick();
        send_beat(mns_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Drop valid and hold until every result beat is back and the core has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_notes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive cycles while the core is idle
    task automatic apply_settings(input logic [8:0] intro, input logic [7:0] mstart,
                                  input logic [8:0] mlen);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= mns_pkg::CFG_INTRO_LENGTH;
        i_cfg_wdata <= intro;
        @(posedge i_clk);
        i_cfg_index <= mns_pkg::CFG_MAIN_START;
        i_cfg_wdata <= {1'b0, mstart};
        @(posedge i_clk);
        i_cfg_index <= mns_pkg::CFG_MAIN_LENGTH;
        i_cfg_wdata <= mlen;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        intro_len  = intro;
        main_start = mstart;
        main_len   = mlen;
    endtask

    // Ticks and unused requests before any start must report silence
    task automatic test_ticks_before_start();
        send_tick();
        send_beat(REQ_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        send_tick();
    endtask

    // Write every store entry so no playback ever reads an unwritten one
    task automatic fill_note_store();
        int a;
        for (a = 0; a < STORE_SIZE; a++) begin
            send_beat(mns_pkg::REQ_WRITE, a[7:0], 8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    // Short intro into a main section that wraps past the top of the store, then restart
    task automatic test_section_wrap();
        int n;
        apply_settings(9'd2, 8'd255, 9'd2);
        send_beat(mns_pkg::REQ_WRITE, 8'd0, 8'h7F, 1'b0);
        send_beat(mns_pkg::REQ_WRITE, 8'd1, 8'h00, 1'b0);
        send_beat(mns_pkg::REQ_WRITE, 8'd255, 8'h01, 1'b0);
        send_beat(mns_pkg::REQ_WRITE, 8'd2, 8'hFF, 1'b1);
        send_beat(mns_pkg::REQ_START, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        for (n = 0; n < 9; n++) send_tick();
        send_beat(mns_pkg::REQ_START, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        send_tick();
    endtask

    // Empty intro: start goes straight to the main section
    task automatic test_empty_intro();
        apply_settings(9'd0, 8'd0, 9'd2);
        send_beat(mns_pkg::REQ_START, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        send_tick();
        send_tick();
    endtask

    // Zero main length: every fetch replays the entry at main_start
    task automatic test_zero_main_length();
        int n;
        apply_settings(9'd0, 8'd255, 9'd0);
        send_beat(mns_pkg::REQ_START, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        for (n = 0; n < 3; n++) send_tick();
    endtask

    // Mostly started playback driven by ticks, mixed with writes, restarts and unused requests
    task automatic test_random_playback();
        int          phase;
        int          n;
        int          pick;
        logic [8:0]  intro;
        logic [7:0]  mstart;
        logic [8:0]  mlen;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin intro = 9'd256; mstart = 8'd0;   mlen = 9'd256; end
                1: begin intro = 9'd0;   mstart = 8'd255; mlen = 9'd1;   end
                2: begin intro = 9'd31;  mstart = 8'd31;  mlen = 9'd212; end
                3: begin intro = 9'd1;   mstart = 8'd200; mlen = 9'd0;   end
                default: begin
                    intro  = 9'($urandom_range(0, 16));
                    mstart = 8'($urandom_range(0, 255));
                    mlen   = 9'($urandom_range(1, 20));
                end
            endcase
            apply_settings(intro, mstart, mlen);
            send_beat(mns_pkg::REQ_START, 8'($urandom), 8'($urandom),
                      1'($urandom_range(0, 1)));
            for (n = 0; n < 110; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    send_tick();
                end else if (pick < 87) begin
                    send_beat(mns_pkg::REQ_WRITE, 8'($urandom), 8'($urandom),
                              1'($urandom_range(0, 1)));
                end else if (pick < 95) begin
                    send_beat(mns_pkg::REQ_START, 8'($urandom), 8'($urandom),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_beat(REQ_UNUSED, 8'($urandom), 8'($urandom),
                              1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic note_mismatch(input string what, input mns_pkg::t_result want,
                                 input mns_pkg::t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s) at %0t: expected half=%0d start=%0d beats=%0d main=%0d,",
                     what, $realtime, want.half_period, want.note_started,
                     want.beats_remaining, want.in_main);
            $display("    got half=%0d start=%0d beats=%0d main=%0d",
                     got.half_period, got.note_started, got.beats_remaining, got.in_main);
        end
    endtask

    // Check each result beat, then pick the next ready level from the stall pattern
    always @(posedge i_clk) begin : result_check
        mns_pkg::t_result got;
        mns_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_half_period, o_note_started, o_beats_remaining, o_in_main};
            if (expected_notes.size() == 0) begin
                note_mismatch("unexpected beat", '0, got);
            end else begin
                want = expected_notes.pop_front();
                if (got.half_period     !== want.half_period  ||
                    got.note_started    !== want.note_started ||
                    got.beats_remaining !== want.beats_remaining ||
                    got.in_main         !== want.in_main) begin
                    note_mismatch("wrong field", want, got);
                end
            end
        end
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(20, 120);
        end
        stall_run--;
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // End the run if neither channel moves a beat for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_IDLE) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ticks_before_start();
        fill_note_store();
        test_section_wrap();
        test_empty_intro();
        test_zero_main_length();
        test_random_playback();
        wait_idle();
        repeat (12) @(posedge i_clk);
        if (expected_notes.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ melody_note_sequencer_core.f @@
hw/rtl/mns_pkg.sv
hw/rtl/mns_ram.sv
hw/rtl/melody_note_sequencer_core.sv
tb/testbench.sv
